@@ src/binary_to_bcd_converter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the binary to BCD converter
// Implication checks, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_BCD_CONVERTER_ASSERT_SVH
`define BINARY_TO_BCD_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define B2BCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B2BCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define B2BCD_ASSERT_NOW(label, ante, cons, msg)
`define B2BCD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ src/b2bcd_pkg.sv @@
// ----------------------------------------------------------------------------
// b2bcd_pkg
// Widths, the work word carried along the cell chain, and the step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package b2bcd_pkg;

  localparam int InputWidth    = 32;
  localparam int DecimalDigits = 10;
  localparam int BcdWidth      = 4 * DecimalDigits;
  localparam int CountWidth    = 4;

  // Work word handed from cell to cell.
  typedef struct packed {
    logic [BcdWidth-1:0]   bcd;       // partial BCD result
    logic [InputWidth-1:0] mag;       // magnitude bits still to shift in, msb first
    logic                  rejected;  // negative input, carried through unconverted
  } b2bcd_work_t;

  // One shift-and-add-3 step: correct every digit of 5 or more, then shift
  // the next magnitude bit into the bottom of the BCD word.
  function automatic b2bcd_work_t dabble_step(input b2bcd_work_t w);
    b2bcd_work_t         r;
    logic [BcdWidth-1:0] adj;
    logic [3:0]          nib;
    adj = w.bcd;
    for (int k = 0; k < DecimalDigits; k++) begin
      nib = w.bcd[4*k +: 4];
      if (nib >= 4'd5) begin
        adj[4*k +: 4] = nib + 4'd3;
      end
    end
    r.bcd      = {adj[BcdWidth-2:0], w.mag[InputWidth-1]};
    r.mag      = {w.mag[InputWidth-2:0], 1'b0};
    r.rejected = w.rejected;
    return r;
  endfunction

  // Significant digits: position of the highest non-zero digit plus one.
  // A positive value of this width never exceeds the kept digits, so no
  // saturation case arises.
  function automatic logic [CountWidth-1:0] count_digits(input logic [BcdWidth-1:0] bcd);
    logic [CountWidth-1:0] cnt;
    cnt = '0;
    for (int k = 0; k < DecimalDigits; k++) begin
      if (bcd[4*k +: 4] != 4'd0) begin
        cnt = CountWidth'(k + 1);
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

@@ src/b2bcd_if.sv @@
// ----------------------------------------------------------------------------
// b2bcd channel interfaces
// Valid/ready channels for the integer request and the BCD result.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2bcd_in_if import b2bcd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [InputWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2bcd_out_if import b2bcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BcdWidth-1:0]   bcd_digits;
  logic [CountWidth-1:0] digit_count;
  logic                  rejected;

  modport source (output valid, output bcd_digits, output digit_count,
                  output rejected, input ready);
  modport sink   (input valid, input bcd_digits, input digit_count,
                  input rejected, output ready);
endinterface

`default_nettype wire

@@ src/b2bcd_cell.sv @@
// ----------------------------------------------------------------------------
// b2bcd_cell
// One double-dabble step with its own register stage and handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module b2bcd_cell import b2bcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  input  b2bcd_work_t up_work,
  output logic        up_ready,
  output logic        dn_valid,
  output b2bcd_work_t dn_work,
  input  logic        dn_ready
);

  // Stage takes a new request when empty or when its content moves on.
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_work <= dabble_step(up_work);
    end
  end

endmodule

`default_nettype wire

@@ src/b2bcd_out.sv @@
// ----------------------------------------------------------------------------
// b2bcd_out
// Result register: digit count and final fields for the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module b2bcd_out import b2bcd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  b2bcd_work_t   up_work,
  output logic          up_ready,
  b2bcd_out_if.source   dout
);

  assign up_ready = !dout.valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (up_ready) begin
      dout.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dout.bcd_digits  <= up_work.bcd;
      dout.digit_count <= count_digits(up_work.bcd);
      dout.rejected    <= up_work.rejected;
    end
  end

endmodule

`default_nettype wire

@@ src/binary_to_bcd_converter.sv @@
// ----------------------------------------------------------------------------
// binary_to_bcd_converter
// Signed 32-bit integer to ten-digit packed BCD with significant digit count.
//
//   Port   Dir   Carries                                   Width
//   din    in    value (two's complement)                  32
//   dout   out   bcd_digits, digit_count, rejected         40 / 4 / 1
//
// One request per cycle is taken, sustained, when dout is not stalled.
// A request passes through cell 0, which loads at the accepting edge, then 31
// more cells, one per input bit, then the result register; 33 stages in all.
// Each stage has its own valid bit; ready ripples back through the chain, so
// empty stages fill while a result waits on dout.
// Reset (rst, synchronous) clears the valid bits only; payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_to_bcd_converter_assert.svh"

module binary_to_bcd_converter import b2bcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  b2bcd_in_if.sink    din,
  b2bcd_out_if.source dout
);

  // Chain taps: index i is the input side of cell i, index InputWidth feeds
  // the result register.
  logic        chain_valid [InputWidth+1];
  logic        chain_ready [InputWidth+1];
  b2bcd_work_t chain_work  [InputWidth+1];

  // Entry: a negative request is flagged and enters with a zero magnitude,
  // so it leaves with all digits zero and a zero count. Zero needs no special
  // handling: the digits stay zero and the count comes out zero.
  assign chain_valid[0]         = din.valid;
  assign chain_work[0].bcd      = '0;
  assign chain_work[0].rejected = din.value[InputWidth-1];
  assign chain_work[0].mag      = din.value[InputWidth-1] ? '0 : din.value;
  assign din.ready              = chain_ready[0];

  // Cell i shifts in input bit InputWidth-1-i.
  for (genvar i = 0; i < InputWidth; i++) begin : g_cell
    b2bcd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_work  (chain_work[i]),
      .up_ready (chain_ready[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_work  (chain_work[i+1]),
      .dn_ready (chain_ready[i+1])
    );
  end

  // Result register with digit count.
  b2bcd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[InputWidth]),
    .up_work  (chain_work[InputWidth]),
    .up_ready (chain_ready[InputWidth]),
    .dout     (dout)
  );

  // A taken request lands in the first cell.
  `B2BCD_ASSERT_NEXT(a_entry_loaded, din.valid && din.ready, chain_valid[1],
                     "request lost at entry")

  // A rejected result carries no digits.
  `B2BCD_ASSERT_NOW(a_reject_empty, dout.valid && dout.rejected,
                    dout.bcd_digits == '0 && dout.digit_count == '0,
                    "rejected result has digits")

  // Count is zero exactly when the digits are all zero.
  `B2BCD_ASSERT_NOW(a_count_match, dout.valid,
                    (dout.digit_count == '0) == (dout.bcd_digits == '0),
                    "digit count disagrees with digits")

  // By the last cell every magnitude bit has been shifted in.
  `B2BCD_ASSERT_NOW(a_mag_drained, chain_valid[InputWidth],
                    chain_work[InputWidth].mag == '0, "magnitude bits left over")

endmodule

`default_nettype wire
